### rtl/ptlik_pkg.sv
// Shared types, fixed widths and angle constants for the planar three-link IK block.
// Angles are held in 1/65536 degree; no dependencies.
package ptlik_pkg;

    // Fixed field and datapath widths
    localparam int LW   = 14;   // link length, unsigned Q14.0
    localparam int CFGW = 15;   // configuration data
    localparam int CIW  = 2;    // configuration register index
    localparam int OANW = 15;   // orientation input
    localparam int PSW  = 25;   // orientation in 1/65536 degree
    localparam int ZW   = 26;   // CORDIC angle accumulator
    localparam int RW   = 33;   // rotation CORDIC x/y, Q30
    localparam int PW   = 48;   // link 3 times sin/cos product
    localparam int TMW  = 18;   // rounded link 3 offset
    localparam int QB   = 30;   // cosine argument quotient bits
    localparam int MW   = 31;   // cosine argument magnitude, Q30
    localparam int CAW  = 32;   // signed cosine argument
    localparam int RADW = 62;   // 1 - c^2 radicand, Q60
    localparam int AAW  = 34;   // acos vectoring CORDIC x/y
    localparam int TW   = 28;   // joint angle sums
    localparam int JW   = 18;   // rounded joint angle
    localparam int OW   = 17;   // joint angle and wrist outputs

    localparam logic signed [ZW-1:0] DEG_QUARTER = 26'sd5898240;
    localparam logic signed [ZW-1:0] DEG_HALF    = 26'sd11796480;
    localparam logic signed [ZW-1:0] DEG_FULL    = 26'sd23592960;
    localparam logic signed [RW-1:0] GAIN_Q30    = 33'sd652032874;
    localparam logic signed [PW-1:0] PROD_RND    = 48'sd536870912;
    localparam logic signed [TW-1:0] ANG_RND     = 28'sd512;
    localparam logic [MW-1:0]        Q30_ONE     = 31'h4000_0000;
    localparam logic [RADW-1:0]      Q60_ONE     = 62'h1000_0000_0000_0000;

    // Configuration register reset values
    localparam logic [LW-1:0]          LINK1_RST = 14'd1475;
    localparam logic [LW-1:0]          LINK2_RST = 14'd1475;
    localparam logic [LW-1:0]          LINK3_RST = 14'd2621;
    localparam logic signed [CFGW-1:0] FLIP_RST  = -15'sd1920;

    typedef enum logic [CIW-1:0] {
        CFG_LINK1 = 2'd0,
        CFG_LINK2 = 2'd1,
        CFG_LINK3 = 2'd2,
        CFG_FLIP  = 2'd3
    } t_cfg_idx;

    // atan(2^-step) in 1/65536 degree
    function automatic logic signed [ZW-1:0] atan_deg(input int step);
        logic signed [ZW-1:0] a;
        case (step)
            0:  a = 26'sd2949120;
            1:  a = 26'sd1740967;
            2:  a = 26'sd919879;
            3:  a = 26'sd466945;
            4:  a = 26'sd234379;
            5:  a = 26'sd117304;
            6:  a = 26'sd58666;
            7:  a = 26'sd29335;
            8:  a = 26'sd14668;
            9:  a = 26'sd7334;
            10: a = 26'sd3667;
            11: a = 26'sd1833;
            12: a = 26'sd917;
            13: a = 26'sd458;
            14: a = 26'sd229;
            15: a = 26'sd115;
            16: a = 26'sd57;
            17: a = 26'sd29;
            18: a = 26'sd14;
            19: a = 26'sd7;
            20: a = 26'sd4;
            21: a = 26'sd2;
            22: a = 26'sd1;
            default: a = 26'sd0;
        endcase
        return a;
    endfunction

endpackage

### rtl/ptlik_cordic_cell.sv
// One registered CORDIC micro-rotation, rotation or vectoring mode.
// Depends on ptlik_pkg for the arctangent table and angle width.
module ptlik_cordic_cell
    import ptlik_pkg::*;
#(
    parameter int XW     = 33,
    parameter int STEP   = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic                 i_clk,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [ZW-1:0] o_z
);

    logic signed [XW-1:0] r_x, r_y, n_x, n_y;
    logic signed [ZW-1:0] r_z, n_z;
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] ang;
    logic                 pos;

    assign dx  = i_y >>> STEP;
    assign dy  = i_x >>> STEP;
    assign ang = atan_deg(STEP);
    // rotate toward zero residual angle, or toward zero y when vectoring
    assign pos = VECTOR ? i_y[XW-1] : ~i_z[ZW-1];

    always_comb begin
        if (pos) begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ang;
        end else begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

### rtl/ptlik_sqrt_cell.sv
// One registered digit of a floor square root: takes two radicand bits, yields one root bit.
// No package dependencies.
module ptlik_sqrt_cell #(
    parameter int W = 36
) (
    input  logic             i_clk,
    input  logic [W-1:0]     i_rad,
    input  logic [W/2:0]     i_rem,
    input  logic [W/2-1:0]   i_root,
    output logic [W-1:0]     o_rad,
    output logic [W/2:0]     o_rem,
    output logic [W/2-1:0]   o_root
);

    localparam int HW = W / 2;

    logic [W-1:0]  r_rad, n_rad;
    logic [HW:0]   r_rem, n_rem;
    logic [HW-1:0] r_root, n_root;
    logic [HW+2:0] sh, trial, diff;
    logic          fit;

    // bring down the next radicand pair and try root*4+1
    assign sh    = {i_rem, i_rad[W-1:W-2]};
    assign trial = {1'b0, i_root, 2'b01};
    assign diff  = sh - trial;
    assign fit   = (sh >= trial);

    always_comb begin
        n_rad  = {i_rad[W-3:0], 2'b00};
        n_root = {i_root[HW-2:0], fit};
        n_rem  = fit ? diff[HW:0] : sh[HW:0];
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

### rtl/ptlik_div_cell.sv
// One registered step of a restoring fractional divide: one quotient bit per cell.
// Depends on ptlik_pkg for the quotient width.
module ptlik_div_cell
    import ptlik_pkg::*;
#(
    parameter int DW = 33
) (
    input  logic          i_clk,
    input  logic [DW-1:0] i_rem,
    input  logic [DW-1:0] i_den,
    input  logic [QB-1:0] i_q,
    output logic [DW-1:0] o_rem,
    output logic [DW-1:0] o_den,
    output logic [QB-1:0] o_q
);

    logic [DW-1:0] r_rem, n_rem, r_den;
    logic [QB-1:0] r_q, n_q;
    logic [DW:0]   sh, diff;
    logic          fit;

    // double the remainder and subtract the divisor where it fits
    assign sh   = {i_rem, 1'b0};
    assign diff = sh - {1'b0, i_den};
    assign fit  = (sh >= {1'b0, i_den});

    always_comb begin
        n_rem = fit ? diff[DW-1:0] : sh[DW-1:0];
        n_q   = {i_q[QB-2:0], fit};
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= i_den;
        r_q   <= n_q;
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_q   = r_q;

endmodule

### rtl/ptlik_delay.sv
// Fixed-length shift line that keeps side data aligned with the cell chains.
// No package dependencies.
module ptlik_delay #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);

    logic [W-1:0] r_tap [D];

    // advance every tap by one each cycle
    always_ff @(posedge i_clk) begin
        r_tap[0] <= i_d;
        for (int k = 1; k < D; k++) begin
            r_tap[k] <= r_tap[k-1];
        end
    end

    assign o_d = r_tap[D-1];

endmodule

### rtl/planar_three_link_inverse_kinematics.sv
// Planar three-link arm inverse kinematics, fully pipelined chains of CORDIC, sqrt and divide cells.
// Between start and o_valid lie the rotation, two square-root, divide and vectoring chains.
// Throughput: one request per cycle; busy stays low and the receiver cannot stall o_valid.
// Reset (synchronous, active low) clears the in-flight valid line and loads the default registers.
// Depends on ptlik_pkg, ptlik_cordic_cell, ptlik_sqrt_cell, ptlik_div_cell and ptlik_delay.
module planar_three_link_inverse_kinematics
    import ptlik_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int COORD_WIDTH       = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CIW-1:0]                i_cfg_index,
    input  logic [CFGW-1:0]               i_cfg_data,
    input  logic signed [COORD_WIDTH-1:0] i_target_x,
    input  logic signed [COORD_WIDTH-1:0] i_target_y,
    input  logic signed [OANW-1:0]        i_orientation,
    output logic                          o_valid,
    output logic signed [OW-1:0]          o_joint1_angle,
    output logic signed [OW-1:0]          o_joint2_angle,
    output logic signed [OW-1:0]          o_joint3_angle,
    output logic signed [OW-1:0]          o_wrist_x,
    output logic signed [OW-1:0]          o_wrist_y,
    output logic                          o_unreachable,
    output logic                          o_flipped
);

    localparam int N    = CORDIC_ITERATIONS;
    localparam int CW   = COORD_WIDTH;
    localparam int WW   = ((CW > 16) ? CW : 16) + 2;  // wrist coordinate
    localparam int R2W  = 2 * WW;                     // squared distance
    localparam int DW   = WW + 15;                    // 2*L*r divisor
    localparam int NW   = R2W + 2;                    // signed numerator
    localparam int DFW  = 2 * LW + 1;                 // L1^2 - L2^2
    localparam int AWW  = WW + 16;                    // wrist vectoring x/y
    localparam int SQ2  = RADW / 2;                   // acos sqrt cells
    localparam int T_Z  = N + 6 + WW;
    localparam int T_Q  = T_Z + 32;
    localparam int T_S  = T_Q + 34;
    localparam int T_A  = T_S + 1 + N;
    localparam int T_OUT = T_A + 4;

    // ---------------- configuration registers ----------------
    logic [LW-1:0]          r_link1, r_link2, r_link3;
    logic signed [CFGW-1:0] r_flip_thr;
    logic                   acc;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;
    assign acc         = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link1    <= LINK1_RST;
            r_link2    <= LINK2_RST;
            r_link3    <= LINK3_RST;
            r_flip_thr <= FLIP_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LINK1: r_link1    <= i_cfg_data[LW-1:0];
                CFG_LINK2: r_link2    <= i_cfg_data[LW-1:0];
                CFG_LINK3: r_link3    <= i_cfg_data[LW-1:0];
                CFG_FLIP:  r_flip_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- request valid line ----------------
    logic [T_OUT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[T_OUT-2:0], acc};
        end
    end

    assign o_valid = r_vld[T_OUT-1];

    // ---------------- orientation reduction ----------------
    logic signed [PSW-1:0] psi_in;
    logic signed [ZW-1:0]  zw, z0;
    logic                  neg0;
    logic signed [ZW-1:0]  r_z0;

    assign psi_in = {i_orientation, 10'b0};

    // wrap into +-180 degrees, then fold into +-90 with a sign flip
    always_comb begin
        zw = ZW'(psi_in);
        if (zw > DEG_HALF) begin
            zw = zw - DEG_FULL;
        end else if (zw < -DEG_HALF) begin
            zw = zw + DEG_FULL;
        end
        neg0 = 1'b0;
        z0   = zw;
        if (zw > DEG_QUARTER) begin
            z0   = zw - DEG_HALF;
            neg0 = 1'b1;
        end else if (zw < -DEG_QUARTER) begin
            z0   = zw + DEG_HALF;
            neg0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_z0 <= z0;
    end

    // ---------------- side data delays from the input ----------------
    logic                   neg_d;
    logic signed [CW-1:0]   tx_d, ty_d;
    logic signed [PSW-1:0]  psi_d;

    ptlik_delay #(.W(1), .D(N + 1)) u_dly_neg (
        .i_clk(i_clk), .i_d(neg0), .o_d(neg_d)
    );
    ptlik_delay #(.W(2 * CW), .D(N + 3)) u_dly_txy (
        .i_clk(i_clk), .i_d({i_target_x, i_target_y}), .o_d({tx_d, ty_d})
    );
    ptlik_delay #(.W(PSW), .D(T_A + 2)) u_dly_psi (
        .i_clk(i_clk), .i_d(psi_in), .o_d(psi_d)
    );

    // ---------------- sin/cos rotation chain ----------------
    logic signed [RW-1:0] rot_x [N+1];
    logic signed [RW-1:0] rot_y [N+1];
    logic signed [ZW-1:0] rot_z [N+1];

    assign rot_x[0] = GAIN_Q30;
    assign rot_y[0] = '0;
    assign rot_z[0] = r_z0;

    for (genvar k = 0; k < N; k++) begin : g_rot
        ptlik_cordic_cell #(.XW(RW), .STEP(k), .VECTOR(1'b0)) u_cell (
            .i_clk(i_clk),
            .i_x(rot_x[k]), .i_y(rot_y[k]), .i_z(rot_z[k]),
            .o_x(rot_x[k+1]), .o_y(rot_y[k+1]), .o_z(rot_z[k+1])
        );
    end

    // ---------------- wrist point ----------------
    logic signed [RW-1:0]  r_cs, r_sn;
    logic signed [LW:0]    l3s;
    logic signed [PW-1:0]  r_pc, r_ps, pcr, psr;
    logic signed [TMW-1:0] term_c, term_s;
    logic signed [WW-1:0]  r_wx, r_wy;
    logic signed [R2W-1:0] r_sqx, r_sqy;
    logic [R2W-1:0]        r_r2;

    assign l3s    = {1'b0, r_link3};
    assign pcr    = r_pc + PROD_RND;
    assign psr    = r_ps + PROD_RND;
    assign term_c = pcr[PW-1:30];
    assign term_s = psr[PW-1:30];

    always_ff @(posedge i_clk) begin
        // undo the half-turn fold
        r_cs  <= neg_d ? -rot_x[N] : rot_x[N];
        r_sn  <= neg_d ? -rot_y[N] : rot_y[N];
        r_pc  <= l3s * r_cs;
        r_ps  <= l3s * r_sn;
        r_wx  <= WW'(tx_d) - WW'(term_c);
        r_wy  <= WW'(ty_d) - WW'(term_s);
        r_sqx <= r_wx * r_wx;
        r_sqy <= r_wy * r_wy;
        r_r2  <= R2W'(unsigned'(r_sqx)) + R2W'(unsigned'(r_sqy));
    end

    // ---------------- wrist distance square root ----------------
    logic [R2W-1:0] s1_rad  [WW+1];
    logic [WW:0]    s1_rem  [WW+1];
    logic [WW-1:0]  s1_root [WW+1];

    assign s1_rad[0]  = r_r2;
    assign s1_rem[0]  = '0;
    assign s1_root[0] = '0;

    for (genvar k = 0; k < WW; k++) begin : g_sq1
        ptlik_sqrt_cell #(.W(R2W)) u_cell (
            .i_clk(i_clk),
            .i_rad(s1_rad[k]), .i_rem(s1_rem[k]), .i_root(s1_root[k]),
            .o_rad(s1_rad[k+1]), .o_rem(s1_rem[k+1]), .o_root(s1_root[k+1])
        );
    end

    logic [R2W-1:0] r2_d;

    ptlik_delay #(.W(R2W), .D(WW)) u_dly_r2 (
        .i_clk(i_clk), .i_d(r_r2), .o_d(r2_d)
    );

    // ---------------- cosine arguments: numerator and divisor ----------------
    logic [2*LW-1:0]       l1sq, l2sq;
    logic signed [DFW-1:0] ldiff;
    logic signed [NW-1:0]  r_num [2];
    logic [DW-1:0]         r_den [2];

    assign l1sq  = r_link1 * r_link1;
    assign l2sq  = r_link2 * r_link2;
    assign ldiff = signed'({1'b0, l1sq}) - signed'({1'b0, l2sq});

    always_ff @(posedge i_clk) begin
        r_num[0] <= signed'({2'b00, r2_d}) + NW'(ldiff);
        r_num[1] <= signed'({2'b00, r2_d}) - NW'(ldiff);
        r_den[0] <= {(DW-1)'(r_link1) * (DW-1)'(s1_root[WW]), 1'b0};
        r_den[1] <= {(DW-1)'(r_link2) * (DW-1)'(s1_root[WW]), 1'b0};
    end

    // magnitude, sign and range check
    logic [NW-2:0] mag   [2];
    logic [DW-1:0] r_rem0 [2];
    logic [DW-1:0] r_dn0  [2];
    logic [1:0]    r_minus, r_clamp, r_eq;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            mag[k] = r_num[k][NW-1] ? (NW-1)'(-r_num[k]) : (NW-1)'(r_num[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 2; k++) begin
            r_rem0[k]  <= mag[k][DW-1:0];
            r_dn0[k]   <= r_den[k];
            r_minus[k] <= r_num[k][NW-1];
            r_clamp[k] <= (r_den[k] == '0) || (mag[k] > (NW-1)'(r_den[k]));
            r_eq[k]    <= (mag[k] == (NW-1)'(r_den[k]));
        end
    end

    // ---------------- fractional divide chains ----------------
    logic [DW-1:0] dv_rem [2][QB+1];
    logic [DW-1:0] dv_den [2][QB+1];
    logic [QB-1:0] dv_q   [2][QB+1];

    for (genvar c = 0; c < 2; c++) begin : g_div
        assign dv_rem[c][0] = r_rem0[c];
        assign dv_den[c][0] = r_dn0[c];
        assign dv_q[c][0]   = '0;
        for (genvar k = 0; k < QB; k++) begin : g_cell
            ptlik_div_cell #(.DW(DW)) u_cell (
                .i_clk(i_clk),
                .i_rem(dv_rem[c][k]), .i_den(dv_den[c][k]), .i_q(dv_q[c][k]),
                .o_rem(dv_rem[c][k+1]), .o_den(dv_den[c][k+1]), .o_q(dv_q[c][k+1])
            );
        end
    end

    logic [1:0] minus_d, clamp_d, eq_d;

    ptlik_delay #(.W(6), .D(QB)) u_dly_flg (
        .i_clk(i_clk),
        .i_d({r_minus, r_clamp, r_eq}),
        .o_d({minus_d, clamp_d, eq_d})
    );

    // ---------------- acos: sine from 1 - c^2 ----------------
    logic [MW-1:0]         qm   [2];
    logic [MW-1:0]         r_m  [2];
    logic signed [CAW-1:0] r_c  [2];
    logic [RADW-1:0]       r_mm [2];
    logic [RADW-1:0]       r_rad [2];
    logic                  r_unr;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            qm[k] = (clamp_d[k] | eq_d[k]) ? Q30_ONE : {1'b0, dv_q[k][QB]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 2; k++) begin
            r_m[k]   <= qm[k];
            r_c[k]   <= minus_d[k] ? -signed'({1'b0, qm[k]}) : signed'({1'b0, qm[k]});
            r_mm[k]  <= r_m[k] * r_m[k];
            r_rad[k] <= Q60_ONE - r_mm[k];
        end
        r_unr <= |clamp_d;
    end

    logic [RADW-1:0] s2_rad  [2][SQ2+1];
    logic [SQ2:0]    s2_rem  [2][SQ2+1];
    logic [SQ2-1:0]  s2_root [2][SQ2+1];

    for (genvar c = 0; c < 2; c++) begin : g_sq2
        assign s2_rad[c][0]  = r_rad[c];
        assign s2_rem[c][0]  = '0;
        assign s2_root[c][0] = '0;
        for (genvar k = 0; k < SQ2; k++) begin : g_cell
            ptlik_sqrt_cell #(.W(RADW)) u_cell (
                .i_clk(i_clk),
                .i_rad(s2_rad[c][k]), .i_rem(s2_rem[c][k]), .i_root(s2_root[c][k]),
                .o_rad(s2_rad[c][k+1]), .o_rem(s2_rem[c][k+1]),
                .o_root(s2_root[c][k+1])
            );
        end
    end

    logic signed [CAW-1:0] c_d [2];
    logic signed [WW-1:0]  wxv_d, wyv_d;

    ptlik_delay #(.W(2 * CAW), .D(SQ2 + 2)) u_dly_c (
        .i_clk(i_clk), .i_d({r_c[0], r_c[1]}), .o_d({c_d[0], c_d[1]})
    );
    ptlik_delay #(.W(2 * WW), .D(T_S - N - 4)) u_dly_wv (
        .i_clk(i_clk), .i_d({r_wx, r_wy}), .o_d({wxv_d, wyv_d})
    );

    // ---------------- atan2 set-up ----------------
    logic signed [AAW-1:0] ax [2], ay [2];
    logic signed [AWW-1:0] wx0, wy0;
    logic signed [AAW-1:0] r_ax [2], r_ay [2];
    logic signed [ZW-1:0]  r_az [2];
    logic signed [AWW-1:0] r_wvx, r_wvy;
    logic signed [ZW-1:0]  r_wvz;
    logic [2:0]            r_zero;

    assign wx0 = AWW'(signed'({wxv_d, 14'b0}));
    assign wy0 = AWW'(signed'({wyv_d, 14'b0}));

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            ax[k] = AAW'(c_d[k]);
            ay[k] = signed'({3'b000, s2_root[k][SQ2]});
        end
    end

    // move the left half-plane to the right, starting from half a turn
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 2; k++) begin
            r_ax[k]   <= ax[k][AAW-1] ? -ax[k] : ax[k];
            r_ay[k]   <= ax[k][AAW-1] ? -ay[k] : ay[k];
            r_az[k]   <= ax[k][AAW-1] ? DEG_HALF : '0;
            r_zero[k] <= (ax[k] == '0) && (ay[k] == '0);
        end
        r_wvx     <= wx0[AWW-1] ? -wx0 : wx0;
        r_wvy     <= wx0[AWW-1] ? -wy0 : wy0;
        r_wvz     <= wx0[AWW-1] ? DEG_HALF : '0;
        r_zero[2] <= (wx0 == '0) && (wy0 == '0);
    end

    // ---------------- vectoring chains ----------------
    logic signed [AAW-1:0] va_x [2][N+1];
    logic signed [AAW-1:0] va_y [2][N+1];
    logic signed [ZW-1:0]  va_z [2][N+1];
    logic signed [AWW-1:0] vw_x [N+1];
    logic signed [AWW-1:0] vw_y [N+1];
    logic signed [ZW-1:0]  vw_z [N+1];

    for (genvar c = 0; c < 2; c++) begin : g_vac
        assign va_x[c][0] = r_ax[c];
        assign va_y[c][0] = r_ay[c];
        assign va_z[c][0] = r_az[c];
        for (genvar k = 0; k < N; k++) begin : g_cell
            ptlik_cordic_cell #(.XW(AAW), .STEP(k), .VECTOR(1'b1)) u_cell (
                .i_clk(i_clk),
                .i_x(va_x[c][k]), .i_y(va_y[c][k]), .i_z(va_z[c][k]),
                .o_x(va_x[c][k+1]), .o_y(va_y[c][k+1]), .o_z(va_z[c][k+1])
            );
        end
    end

    assign vw_x[0] = r_wvx;
    assign vw_y[0] = r_wvy;
    assign vw_z[0] = r_wvz;

    for (genvar k = 0; k < N; k++) begin : g_vwr
        ptlik_cordic_cell #(.XW(AWW), .STEP(k), .VECTOR(1'b1)) u_cell (
            .i_clk(i_clk),
            .i_x(vw_x[k]), .i_y(vw_y[k]), .i_z(vw_z[k]),
            .o_x(vw_x[k+1]), .o_y(vw_y[k+1]), .o_z(vw_z[k+1])
        );
    end

    logic [2:0] zero_d;

    ptlik_delay #(.W(3), .D(N)) u_dly_zero (
        .i_clk(i_clk), .i_d(r_zero), .o_d(zero_d)
    );

    // ---------------- joint angles ----------------
    logic signed [ZW-1:0] angr [3];
    logic signed [ZW-1:0] r_ang [3];
    logic signed [TW-1:0] r_t1, r_t2, r_t3, t1r, t2r, t3r;
    logic signed [JW-1:0] r_j1, r_j2, j3, jn1, jn2, jn3;
    logic                 flip;

    assign angr[0] = va_z[0][N];
    assign angr[1] = va_z[1][N];
    assign angr[2] = vw_z[N];

    // drop the origin case to zero and wrap above half a turn
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (zero_d[k]) begin
                r_ang[k] <= '0;
            end else if (angr[k] > DEG_HALF) begin
                r_ang[k] <= angr[k] - DEG_FULL;
            end else begin
                r_ang[k] <= angr[k];
            end
        end
    end

    assign t1r = r_t1 + ANG_RND;
    assign t2r = r_t2 + ANG_RND;
    assign t3r = r_t3 + ANG_RND;

    always_ff @(posedge i_clk) begin
        r_t1 <= TW'(r_ang[2]) - TW'(r_ang[0]);
        r_t2 <= TW'(r_ang[0]) + TW'(r_ang[1]);
        r_t3 <= TW'(psi_d) - r_t1 - r_t2;
        r_j1 <= t1r[TW-1:10];
        r_j2 <= t2r[TW-1:10];
    end

    logic                 unr_d;
    logic signed [WW-1:0] wxo_d, wyo_d;

    ptlik_delay #(.W(1), .D(T_A + 2 - T_Q)) u_dly_unr (
        .i_clk(i_clk), .i_d(r_unr), .o_d(unr_d)
    );
    ptlik_delay #(.W(2 * WW), .D(T_A - N - 1)) u_dly_wo (
        .i_clk(i_clk), .i_d({r_wx, r_wy}), .o_d({wxo_d, wyo_d})
    );

    // negate all three when joint 1 falls below the threshold
    assign j3   = t3r[TW-1:10];
    assign flip = r_j1 < JW'(r_flip_thr);
    assign jn1  = flip ? -r_j1 : r_j1;
    assign jn2  = flip ? -r_j2 : r_j2;
    assign jn3  = flip ? -j3 : j3;

    // ---------------- output register ----------------
    logic signed [OW-1:0] r_oj1, r_oj2, r_oj3, r_owx, r_owy;
    logic                 r_ounr, r_oflp;

    always_ff @(posedge i_clk) begin
        r_oj1  <= jn1[OW-1:0];
        r_oj2  <= jn2[OW-1:0];
        r_oj3  <= jn3[OW-1:0];
        r_owx  <= wxo_d[OW-1:0];
        r_owy  <= wyo_d[OW-1:0];
        r_ounr <= unr_d;
        r_oflp <= flip;
    end

    assign o_joint1_angle = r_oj1;
    assign o_joint2_angle = r_oj2;
    assign o_joint3_angle = r_oj3;
    assign o_wrist_x      = r_owx;
    assign o_wrist_y      = r_owy;
    assign o_unreachable  = r_ounr;
    assign o_flipped      = r_oflp;

endmodule

### verif/planar_three_link_inverse_kinematics_tb.sv
// Testbench for planar_three_link_inverse_kinematics: directed and random target requests
// checked against a bit-exact fixed-point IK predictor. Depends on ptlik_pkg and the RTL.
`timescale 1ns / 100ps

module planar_three_link_inverse_kinematics_tb;
    import ptlik_pkg::*;

    localparam int  LATENCY     = 127;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  ITERS       = 16;

    typedef struct packed {
        logic signed [OW-1:0] j1;
        logic signed [OW-1:0] j2;
        logic signed [OW-1:0] j3;
        logic signed [OW-1:0] wx;
        logic signed [OW-1:0] wy;
        logic                 unreach;
        logic                 flip;
    } t_pose;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CIW-1:0]         i_cfg_index = '0;
    logic [CFGW-1:0]        i_cfg_data = '0;
    logic signed [15:0]     i_target_x = '0;
    logic signed [15:0]     i_target_y = '0;
    logic signed [OANW-1:0] i_orientation = '0;
    logic                   o_valid;
    logic signed [OW-1:0]   o_joint1_angle, o_joint2_angle, o_joint3_angle;
    logic signed [OW-1:0]   o_wrist_x, o_wrist_y;
    logic                   o_unreachable, o_flipped;

    // Predictor copy of the configuration
    longint link1_len, link2_len, link3_len, flip_thr;

    t_pose pending_poses[$];
    int    mismatch_cnt = 0;
    int    cycle_cnt = 0;
    bit    allow_gaps = 1'b1;

    planar_three_link_inverse_kinematics DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Fixed-point model helpers
    function automatic longint unsigned isqrt64(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void rotate_sincos(input longint z_in, output longint c, output longint s);
        longint x, y, z, dx, dy;
        bit     neg;
        x = GAIN_Q30;
        y = 0;
        z = z_in;
        neg = 1'b0;
        if (z > DEG_HALF) z -= DEG_FULL;
        if (z < -DEG_HALF) z += DEG_FULL;
        if (z > DEG_QUARTER) begin
            z -= DEG_HALF;
            neg = 1'b1;
        end else if (z < -DEG_QUARTER) begin
            z += DEG_HALF;
            neg = 1'b1;
        end
        for (int i = 0; i < ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_deg(i);
            end else begin
                x += dx; y -= dy; z += atan_deg(i);
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    function automatic longint vector_angle(input longint y_in, input longint x_in);
        longint x, y, z, dx, dy;
        x = x_in;
        y = y_in;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            x = -x; y = -y; z = DEG_HALF;
        end
        for (int i = 0; i < ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_deg(i);
            end else begin
                x -= dx; y += dy; z -= atan_deg(i);
            end
        end
        if (z > DEG_HALF) z -= DEG_FULL;
        return z;
    endfunction

    function automatic longint arccos_deg(input longint c);
        longint unsigned m;
        m = (c < 0) ? -c : c;
        return vector_angle(longint'(isqrt64(64'h1000_0000_0000_0000 - m * m)), c);
    endfunction

    // Law-of-cosines argument in Q30, clamped and flagged when out of range
    function automatic longint cosine_arg(input longint unsigned a, input longint unsigned b,
                                          input longint unsigned r2, input longint unsigned z,
                                          inout bit flag);
        longint unsigned pos, negp, mag, den, rem, q;
        bit minus;
        pos = r2 + a * a;
        negp = b * b;
        minus = pos < negp;
        mag = minus ? negp - pos : pos - negp;
        den = 2 * a * z;
        q = 0;
        if (den == 0 || mag > den) begin
            flag = 1'b1;
            return minus ? -(64'sd1 <<< 30) : (64'sd1 <<< 30);
        end
        if (mag == den) begin
            q = 64'd1 << 30;
        end else begin
            rem = mag;
            for (int k = 0; k < 30; k++) begin
                rem <<= 1;
                q <<= 1;
                if (rem >= den) begin
                    rem -= den;
                    q |= 1;
                end
            end
        end
        return minus ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_pose solve_pose(input logic signed [15:0] tx,
                                         input logic signed [15:0] ty,
                                         input logic signed [OANW-1:0] orient);
        longint psi, cs, sn, wx, wy, c1, c2, a1, a2, t1, t2, t3, j1, j2, j3;
        longint unsigned r2, z;
        bit unr, flp;
        t_pose p;
        unr = 1'b0;
        flp = 1'b0;
        psi = longint'(orient) * 1024;
        rotate_sincos(psi, cs, sn);
        wx = longint'(tx) - ((link3_len * cs + (64'sd1 <<< 29)) >>> 30);
        wy = longint'(ty) - ((link3_len * sn + (64'sd1 <<< 29)) >>> 30);
        r2 = longint'(wx * wx) + longint'(wy * wy);
        z = isqrt64(r2);
        c1 = cosine_arg(link1_len, link2_len, r2, z, unr);
        c2 = cosine_arg(link2_len, link1_len, r2, z, unr);
        a1 = arccos_deg(c1);
        a2 = arccos_deg(c2);
        t1 = vector_angle(wy * 16384, wx * 16384) - a1;
        t2 = a1 + a2;
        t3 = psi - t1 - t2;
        j1 = (t1 + 512) >>> 10;
        j2 = (t2 + 512) >>> 10;
        j3 = (t3 + 512) >>> 10;
        if (j1 < flip_thr) begin
            flp = 1'b1;
            j1 = -j1; j2 = -j2; j3 = -j3;
        end
        p.j1 = j1[OW-1:0];
        p.j2 = j2[OW-1:0];
        p.j3 = j3[OW-1:0];
        p.wx = wx[OW-1:0];
        p.wy = wy[OW-1:0];
        p.unreach = unr;
        p.flip = flp;
        return p;
    endfunction

    // Compare each result with the oldest pending pose
    always @(posedge i_clk) begin
        t_pose exp_p;
        if (i_rst_n && o_valid) begin
            if (pending_poses.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("ERROR: result with no pending request");
            end else begin
                exp_p = pending_poses.pop_front();
                if (o_joint1_angle !== exp_p.j1 || o_joint2_angle !== exp_p.j2 ||
                    o_joint3_angle !== exp_p.j3 || o_wrist_x !== exp_p.wx ||
                    o_wrist_y !== exp_p.wy || o_unreachable !== exp_p.unreach ||
                    o_flipped !== exp_p.flip) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("ERROR: exp j=%0d/%0d/%0d w=%0d/%0d u=%0b f=%0b",
                                 exp_p.j1, exp_p.j2, exp_p.j3, exp_p.wx, exp_p.wy,
                                 exp_p.unreach, exp_p.flip);
                        $display("       got j=%0d/%0d/%0d w=%0d/%0d u=%0b f=%0b",
                                 o_joint1_angle, o_joint2_angle, o_joint3_angle,
                                 o_wrist_x, o_wrist_y, o_unreachable, o_flipped);
                    end
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("planar_three_link_inverse_kinematics_tb NOT OK");
            $finish;
        end
    end

    // Send one target request, with an optional idle burst before it
    task automatic send_target(input logic signed [15:0] tx, input logic signed [15:0] ty,
                               input logic signed [OANW-1:0] orient);
        @(negedge i_clk);
        if (allow_gaps && $urandom_range(3) == 0) begin
            start = 1'b0;
            repeat ($urandom_range(16, 1)) @(negedge i_clk);
        end
        start = 1'b1;
        i_target_x = tx;
        i_target_y = ty;
        i_orientation = orient;
        do @(posedge i_clk); while (busy);
        pending_poses.push_back(solve_pose(tx, ty, orient));
    endtask

    // Hold until every pending result has come back
    task automatic drain;
        @(negedge i_clk);
        start = 1'b0;
        while (pending_poses.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFGW-1:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_LINK1: link1_len = value[LW-1:0];
            CFG_LINK2: link2_len = value[LW-1:0];
            CFG_LINK3: link3_len = value[LW-1:0];
            CFG_FLIP:  flip_thr = longint'($signed(value));
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_arm(input int l1, input int l2, input int l3, input int thr);
        drain();
        write_reg(CFG_LINK1, CFGW'(l1));
        write_reg(CFG_LINK2, CFGW'(l2));
        write_reg(CFG_LINK3, CFGW'(l3));
        write_reg(CFG_FLIP, CFGW'(thr));
    endtask

    function automatic logic signed [OANW-1:0] rand_orient();
        return OANW'($signed($urandom_range(23040)) - 15'sd11520);
    endfunction

    // Field extremes, wrist at base, flip and unreachable cases at reset lengths
    task automatic test_directed_extremes;
        send_target(16'sd0, 16'sd0, 15'sd0);
        send_target(16'sh7FFF, 16'sh7FFF, 15'sd11520);
        send_target(-16'sh8000, -16'sh8000, -15'sd11520);
        send_target(-16'sh8000, 16'sh7FFF, 15'sd0);
        send_target(16'sh7FFF, -16'sh8000, 15'sd5760);
        send_target(16'sd2621, 16'sd0, 15'sd0);
        send_target(16'sd0, 16'sd2621, 15'sd5760);
        send_target(16'sd3500, 16'sd1000, 15'sd0);
        send_target(16'sd3500, -16'sd1500, -15'sd2000);
        send_target(16'sd2700, -16'sd2500, -15'sd5760);
        send_target(-16'sd3000, 16'sd1000, 15'sd11520);
        send_target(16'sd5571, 16'sd0, 15'sd0);
        send_target(16'sd2621, 16'sd2950, 15'sd0);
        send_target(16'sd100, 16'sd100, -15'sd8000);
    endtask

    // Zero links force the zero-denominator clamp
    task automatic test_zero_links;
        set_arm(0, 0, 0, 0);
        send_target(16'sd0, 16'sd0, 15'sd0);
        send_target(16'sd1000, -16'sd1000, 15'sd3000);
        send_target(-16'sd1, 16'sd0, -15'sd11520);
        set_arm(0, 1475, 2621, -11520);
        send_target(16'sd3000, 16'sd500, 15'sd0);
        send_target(-16'sd3000, -16'sd500, 15'sd7000);
    endtask

    // Random requests, mostly within reach of the current arm
    task automatic test_random_reach(input int count, input int span);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) < 8)
                send_target(16'($signed($urandom_range(2 * span)) - span),
                            16'($signed($urandom_range(2 * span)) - span), rand_orient());
            else
                send_target(16'($urandom), 16'($urandom), rand_orient());
        end
    endtask

    task automatic test_config_sweep;
        set_arm(16383, 16383, 16383, 11520);
        test_random_reach(180, 32767);
        set_arm(16383, 1, 8000, -11520);
        test_random_reach(150, 32767);
        set_arm(3000, 5000, 1000, 0);
        test_random_reach(180, 9000);
        for (int ph = 0; ph < 3; ph++) begin
            set_arm($urandom_range(16383, 200), $urandom_range(16383, 200),
                    $urandom_range(16383), $signed($urandom_range(23040)) - 11520);
            test_random_reach(150, 12000);
        end
    endtask

    task automatic test_reset_lengths;
        set_arm(LINK1_RST, LINK2_RST, LINK3_RST, FLIP_RST);
        test_random_reach(250, 5200);
        allow_gaps = 1'b0;
        test_random_reach(150, 5200);
    endtask

    initial begin
        link1_len = LINK1_RST;
        link2_len = LINK2_RST;
        link3_len = LINK3_RST;
        flip_thr = FLIP_RST;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_extremes();
        test_random_reach(70, 5200);
        test_zero_links();
        test_config_sweep();
        test_reset_lengths();
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_poses.size() == 0) begin
            $display("planar_three_link_inverse_kinematics_tb OK");
        end else begin
            $display("planar_three_link_inverse_kinematics_tb NOT OK");
        end
        $finish;
    end

endmodule

### planar_three_link_inverse_kinematics.f
rtl/ptlik_pkg.sv
rtl/ptlik_cordic_cell.sv
rtl/ptlik_sqrt_cell.sv
rtl/ptlik_div_cell.sv
rtl/ptlik_delay.sv
rtl/planar_three_link_inverse_kinematics.sv
verif/planar_three_link_inverse_kinematics_tb.sv
